### design/sfc_pkg.sv
package sfc_pkg;

   // Frame and field geometry
   localparam int unsigned FRAME_DIM  = 4096;
   localparam int unsigned PIX_W      = 12;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REACH_W    = 15;

   // Q2.14 rotation: one in fixed point, rounding offset and shift
   localparam logic signed [15:0] COS_ONE    = 16'sd16384;
   localparam int unsigned        Q_SHIFT    = 14;
   localparam logic [34:0]        Q_HALF     = 35'd8192;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_MODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_X      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_Y      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_X   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_Y   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_COS    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_SIN    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_REACH      = 4'd7;

   typedef enum logic [1:0] {
      MODE_CIRCLE    = 2'd0,
      MODE_SQUARE    = 2'd1,
      MODE_AXIS_RECT = 2'd2,
      MODE_ROT_RECT  = 2'd3
   } mode_type;

   // Shape description held by the register file
   typedef struct packed {
      mode_type                shape_mode;
      logic signed [15:0]      ref_x;
      logic signed [15:0]      ref_y;
      logic signed [15:0]      extent_x;
      logic signed [15:0]      extent_y;
      logic signed [15:0]      rot_cos;
      logic signed [15:0]      rot_sin;
      logic [REACH_W-1:0]      reach;
   } cfg_type;

   // Product stage contents handed to the evaluation stage
   typedef struct packed {
      logic                    valid;
      logic                    in_frame;
      logic                    span_r;
      logic                    span_reach;
      logic                    axis_hit;
      logic [31:0]             dx_sq;
      logic [31:0]             dy_sq;
      logic [31:0]             r_sq;
      logic signed [32:0]      dx_cos;
      logic signed [32:0]      dy_sin;
      logic signed [32:0]      dy_cos;
      logic signed [32:0]      dx_sin;
   } prod_type;

endpackage

### design/sfc_csr.sv
module sfc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output sfc_pkg::cfg_type                   cfg
);

   sfc_pkg::cfg_type cfg_ff;
   sfc_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;
   assign cfg       = cfg_ff;

   // Decode the write; unknown indexes leave the registers alone
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            sfc_pkg::CSR_SHAPE_MODE: cfg_in.shape_mode = sfc_pkg::mode_type'(csr_wdata[1:0]);
            sfc_pkg::CSR_REF_X:      cfg_in.ref_x      = $signed(csr_wdata);
            sfc_pkg::CSR_REF_Y:      cfg_in.ref_y      = $signed(csr_wdata);
            sfc_pkg::CSR_EXTENT_X:   cfg_in.extent_x   = $signed(csr_wdata);
            sfc_pkg::CSR_EXTENT_Y:   cfg_in.extent_y   = $signed(csr_wdata);
            sfc_pkg::CSR_ROT_COS:    cfg_in.rot_cos    = $signed(csr_wdata);
            sfc_pkg::CSR_ROT_SIN:    cfg_in.rot_sin    = $signed(csr_wdata);
            sfc_pkg::CSR_REACH:      cfg_in.reach      = csr_wdata[sfc_pkg::REACH_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the shape registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shape_mode <= sfc_pkg::MODE_CIRCLE;
         cfg_ff.ref_x      <= '0;
         cfg_ff.ref_y      <= '0;
         cfg_ff.extent_x   <= '0;
         cfg_ff.extent_y   <= '0;
         cfg_ff.rot_cos    <= sfc_pkg::COS_ONE;
         cfg_ff.rot_sin    <= '0;
         cfg_ff.reach      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/sfc_prod.sv
module sfc_prod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_take,
   input  logic [sfc_pkg::PIX_W-1:0]     req_pixel_x,
   input  logic [sfc_pkg::PIX_W-1:0]     req_pixel_y,
   input  sfc_pkg::cfg_type              cfg,
   output sfc_pkg::prod_type             prod
);

   logic                        a_valid_ff;
   logic [sfc_pkg::PIX_W-1:0]   px_ff;
   logic [sfc_pkg::PIX_W-1:0]   py_ff;
   sfc_pkg::prod_type           prod_ff;
   sfc_pkg::prod_type           prod_in;

   logic signed [16:0]          dx;
   logic signed [16:0]          dy;
   logic signed [16:0]          px_s;
   logic signed [16:0]          py_s;
   logic signed [16:0]          r_s;
   logic signed [16:0]          reach_s;
   logic signed [15:0]          x_lo;
   logic signed [15:0]          x_hi;
   logic signed [15:0]          y_lo;
   logic signed [15:0]          y_hi;
   logic signed [33:0]          dx_sq_full;
   logic signed [33:0]          dy_sq_full;
   logic signed [31:0]          r_sq_full;

   // True when -r <= d < r
   function automatic logic in_span(input logic signed [16:0] d,
                                    input logic signed [16:0] r);
      logic signed [17:0] neg_r;
      neg_r = -{r[16], r};
      return ($signed({d[16], d}) >= neg_r) && (d < r);
   endfunction

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         px_ff <= req_pixel_x;
         py_ff <= req_pixel_y;
      end
   end

   // Offsets from the reference point and sorted corners
   assign px_s    = $signed({5'd0, px_ff});
   assign py_s    = $signed({5'd0, py_ff});
   assign dx      = px_s - 17'(cfg.ref_x);
   assign dy      = py_s - 17'(cfg.ref_y);
   assign r_s     = 17'(cfg.extent_x);
   assign reach_s = $signed({2'd0, cfg.reach});

   assign x_lo = (cfg.ref_x > cfg.extent_x) ? cfg.extent_x : cfg.ref_x;
   assign x_hi = (cfg.ref_x > cfg.extent_x) ? cfg.ref_x    : cfg.extent_x;
   assign y_lo = (cfg.ref_y > cfg.extent_y) ? cfg.extent_y : cfg.ref_y;
   assign y_hi = (cfg.ref_y > cfg.extent_y) ? cfg.ref_y    : cfg.extent_y;

   // Independent products, each registered before use
   assign dx_sq_full = dx * dx;
   assign dy_sq_full = dy * dy;
   assign r_sq_full  = cfg.extent_x * cfg.extent_x;

   always_comb begin
      prod_in.valid      = a_valid_ff;
      prod_in.in_frame   = (32'(px_ff) < sfc_pkg::FRAME_DIM) &&
                           (32'(py_ff) < sfc_pkg::FRAME_DIM);
      prod_in.span_r     = in_span(dx, r_s) && in_span(dy, r_s);
      prod_in.span_reach = in_span(dx, reach_s) && in_span(dy, reach_s);
      prod_in.axis_hit   = (px_s >= 17'(x_lo)) && (px_s < 17'(x_hi)) &&
                           (py_s >= 17'(y_lo)) && (py_s < 17'(y_hi));
      prod_in.dx_sq      = dx_sq_full[31:0];
      prod_in.dy_sq      = dy_sq_full[31:0];
      prod_in.r_sq       = r_sq_full;
      prod_in.dx_cos     = dx * cfg.rot_cos;
      prod_in.dy_sin     = dy * cfg.rot_sin;
      prod_in.dy_cos     = dy * cfg.rot_cos;
      prod_in.dx_sin     = dx * cfg.rot_sin;
   end

   // Advance into the product register
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
      end else begin
         prod_ff.valid <= prod_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff.in_frame   <= prod_in.in_frame;
      prod_ff.span_r     <= prod_in.span_r;
      prod_ff.span_reach <= prod_in.span_reach;
      prod_ff.axis_hit   <= prod_in.axis_hit;
      prod_ff.dx_sq      <= prod_in.dx_sq;
      prod_ff.dy_sq      <= prod_in.dy_sq;
      prod_ff.r_sq       <= prod_in.r_sq;
      prod_ff.dx_cos     <= prod_in.dx_cos;
      prod_ff.dy_sin     <= prod_in.dy_sin;
      prod_ff.dy_cos     <= prod_in.dy_cos;
      prod_ff.dx_sin     <= prod_in.dx_sin;
   end

   assign prod = prod_ff;

endmodule

### design/sfc_eval.sv
module sfc_eval (
   input  logic                 clock,
   input  logic                 reset,
   input  sfc_pkg::cfg_type     cfg,
   input  sfc_pkg::prod_type    prod,
   output logic                 rsp_valid,
   output logic                 rsp_covered
);

   logic               valid_ff;
   logic               covered_ff;
   logic               covered_in;
   logic [32:0]        dist_sq;
   logic signed [33:0] u_val;
   logic signed [33:0] v_val;
   logic               circle_hit;
   logic               rot_hit;

   // Round half away from zero in Q14, then test -w < 2*a < w; the test is
   // symmetric, so only the rounded magnitude matters
   function automatic logic half_inside(input logic signed [33:0] q,
                                        input logic signed [15:0] w);
      logic [34:0]        mag;
      logic [20:0]        rnd;
      logic signed [22:0] twice;
      mag   = q[33] ? 35'(-{q[33], q}) : 35'({1'b0, q});
      mag   = mag + sfc_pkg::Q_HALF;
      rnd   = mag[sfc_pkg::Q_SHIFT +: 21];
      twice = $signed({1'b0, rnd, 1'b0});
      return twice < 23'(w);
   endfunction

   // Finish the rotated offsets and the distance
   assign u_val      = 34'(prod.dx_cos) + 34'(prod.dy_sin);
   assign v_val      = 34'(prod.dy_cos) - 34'(prod.dx_sin);
   assign dist_sq    = {1'b0, prod.dx_sq} + {1'b0, prod.dy_sq};
   assign circle_hit = prod.span_r && (dist_sq <= {1'b0, prod.r_sq});
   assign rot_hit    = prod.span_reach && half_inside(u_val, cfg.extent_x) &&
                       half_inside(v_val, cfg.extent_y);

   // Select the test of the current mode
   always_comb begin
      case (cfg.shape_mode)
         sfc_pkg::MODE_CIRCLE:    covered_in = circle_hit;
         sfc_pkg::MODE_SQUARE:    covered_in = prod.span_r;
         sfc_pkg::MODE_AXIS_RECT: covered_in = prod.axis_hit;
         sfc_pkg::MODE_ROT_RECT:  covered_in = rot_hit;
         default:                 covered_in = 1'b0;
      endcase
      covered_in = covered_in && prod.in_frame && prod.valid;
   end

   // Drive the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         covered_ff <= 1'b0;
      end else begin
         valid_ff   <= prod.valid;
         covered_ff <= covered_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_covered = covered_ff;

endmodule

### design/shape_fill_coverage_test.sv
// Channel    Direction  Handshake                 Payload
// request    in         start, busy               req_pixel_x, req_pixel_y
// response   out        rsp_valid (strobe)        rsp_covered
// csr write  in         csr_valid, csr_ready      csr_index, csr_wdata
//
// One request is taken every clock; busy never rises.
// The result passes the input register, the product register (the seven
// multipliers) and the result register before it strobes.
// Synchronous active-high reset clears the stage valids and the shape registers, but for
// the cosine, set to one; the receiver cannot stall, so nothing holds a result back.
module shape_fill_coverage_test (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [sfc_pkg::PIX_W-1:0]          req_pixel_x,
   input  logic [sfc_pkg::PIX_W-1:0]          req_pixel_y,
   output logic                               rsp_valid,
   output logic                               rsp_covered,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   sfc_pkg::cfg_type  cfg;
   sfc_pkg::prod_type prod;
   logic              req_take;

   assign busy     = 1'b0;
   assign req_take = start & ~busy;

   sfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sfc_prod u_prod (
      .clock       (clock),
      .reset       (reset),
      .req_take    (req_take),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .cfg         (cfg),
      .prod        (prod)
   );

   sfc_eval u_eval (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .prod        (prod),
      .rsp_valid   (rsp_valid),
      .rsp_covered (rsp_covered)
   );

   // Every request yields a result
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##3 rsp_valid)
      else $error("request lost in pipeline");

   // No result without a matching earlier request
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_take, 3))
      else $error("result without request");

   // Coverage is only reported with a strobe
   a_cov_strobed: assert property (@(posedge clock) disable iff (reset)
      rsp_covered |-> rsp_valid)
      else $error("covered set outside a result");

endmodule

### test/shape_fill_coverage_test_checker.sv
`timescale 1ns / 100ps

module shape_fill_coverage_test_checker
   import sfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [PIX_W-1:0]      req_pixel_x,
   input  logic [PIX_W-1:0]      req_pixel_y,
   input  logic                  rsp_valid,
   input  logic                  rsp_covered,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           error_count,
   output int unsigned           pending_count
);

   localparam logic signed [39:0] HALF_LSB  = 40'sd8192;

   typedef struct {
      logic [PIX_W-1:0] col;
      logic [PIX_W-1:0] row;
      logic             covered;
   } pixel_verdict_type;

   pixel_verdict_type pending_verdicts[$];
   cfg_type           shape_cfg;
   int unsigned       mismatches = 0;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // Half-open span test: -r <= d < r, empty for r <= 0
   function automatic logic in_span(logic signed [17:0] d, logic signed [17:0] r);
      return (d >= -r) && (d < r);
   endfunction

   // Q14 to integer, ties rounded away from zero
   function automatic logic signed [39:0] round_q14(logic signed [39:0] v);
      if (v >= 0) begin
         return (v + HALF_LSB) >>> Q_SHIFT;
      end
      return -((-v + HALF_LSB) >>> Q_SHIFT);
   endfunction

   // Decide whether the configured shape covers one pixel
   function automatic logic shape_covers(cfg_type c, logic [PIX_W-1:0] px,
                                         logic [PIX_W-1:0] py);
      logic signed [17:0] col, row, rx, ry, ex, ey, rch, dx, dy;
      logic signed [17:0] lo_x, hi_x, lo_y, hi_y;
      logic signed [39:0] dx_w, dy_w, r_w, cs, sn, u, v, ax, ay, w, h;
      logic               hit;
      col  = {6'd0, px};
      row  = {6'd0, py};
      rx   = c.ref_x;
      ry   = c.ref_y;
      ex   = c.extent_x;
      ey   = c.extent_y;
      rch  = {3'd0, c.reach};
      dx   = col - rx;
      dy   = row - ry;
      dx_w = dx;
      dy_w = dy;
      r_w  = ex;
      w    = ex;
      h    = ey;
      cs   = c.rot_cos;
      sn   = c.rot_sin;
      hit  = 1'b0;
      case (c.shape_mode)
         MODE_CIRCLE: begin
            hit = in_span(dx, ex) && in_span(dy, ex) &&
                  (dx_w * dx_w + dy_w * dy_w <= r_w * r_w);
         end
         MODE_SQUARE: begin
            hit = in_span(dx, ex) && in_span(dy, ex);
         end
         MODE_AXIS_RECT: begin
            // put the corners in order per axis
            lo_x = (rx > ex) ? ex : rx;
            hi_x = (rx > ex) ? rx : ex;
            lo_y = (ry > ey) ? ey : ry;
            hi_y = (ry > ey) ? ry : ey;
            hit  = (col >= lo_x) && (col < hi_x) && (row >= lo_y) && (row < hi_y);
         end
         MODE_ROT_RECT: begin
            if (in_span(dx, rch) && in_span(dy, rch)) begin
               u   = dx_w * cs + dy_w * sn;
               v   = dy_w * cs - dx_w * sn;
               ax  = round_q14(u);
               ay  = round_q14(v);
               hit = (2 * ax > -w) && (2 * ax < w) && (2 * ay > -h) && (2 * ay < h);
            end
         end
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Match results, record accepted requests, shadow register writes
   always @(posedge clock) begin : track
      pixel_verdict_type head;
      if (reset) begin
         pending_verdicts.delete();
         shape_cfg.shape_mode = MODE_CIRCLE;
         shape_cfg.ref_x      = '0;
         shape_cfg.ref_y      = '0;
         shape_cfg.extent_x   = '0;
         shape_cfg.extent_y   = '0;
         shape_cfg.rot_cos    = COS_ONE;
         shape_cfg.rot_sin    = '0;
         shape_cfg.reach      = '0;
      end else begin
         if (rsp_valid) begin
            if (pending_verdicts.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result: expected none, actual covered=%0b",
                        $time, rsp_covered);
            end else begin
               head = pending_verdicts.pop_front();
               if (rsp_covered !== head.covered) begin
                  mismatches++;
                  $display("%0t: covered at pixel (%0d,%0d): expected %0b, actual %0b",
                           $time, head.col, head.row, head.covered, rsp_covered);
               end
            end
         end
         if (start && !busy) begin
            pending_verdicts.push_back('{col: req_pixel_x, row: req_pixel_y,
               covered: shape_covers(shape_cfg, req_pixel_x, req_pixel_y)});
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SHAPE_MODE: shape_cfg.shape_mode = mode_type'(csr_wdata[1:0]);
               CSR_REF_X:      shape_cfg.ref_x      = csr_wdata;
               CSR_REF_Y:      shape_cfg.ref_y      = csr_wdata;
               CSR_EXTENT_X:   shape_cfg.extent_x   = csr_wdata;
               CSR_EXTENT_Y:   shape_cfg.extent_y   = csr_wdata;
               CSR_ROT_COS:    shape_cfg.rot_cos    = csr_wdata;
               CSR_ROT_SIN:    shape_cfg.rot_sin    = csr_wdata;
               CSR_REACH:      shape_cfg.reach      = csr_wdata[REACH_W-1:0];
               default: ;
            endcase
         end
      end
      error_count   <= mismatches;
      pending_count <= pending_verdicts.size();
   end

endmodule

### test/shape_fill_coverage_test_tb.sv
`timescale 1ns / 100ps

module shape_fill_coverage_test_tb;
   import sfc_pkg::*;

   localparam int PIX_MAX     = FRAME_DIM - 1;
   localparam int TARGET_REQS = 1300;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [PIX_W-1:0]      req_pixel_x;
   logic [PIX_W-1:0]      req_pixel_y;
   logic                  rsp_valid;
   logic                  rsp_covered;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           error_count;
   int unsigned           pending_count;

   cfg_type     shape;
   int          burst_left = 0;
   int          reqs_sent  = 0;

   always #6 clock = ~clock;

   shape_fill_coverage_test dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .rsp_valid   (rsp_valid),
      .rsp_covered (rsp_covered),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   shape_fill_coverage_test_checker coverage_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel_x   (req_pixel_x),
      .req_pixel_y   (req_pixel_y),
      .rsp_valid     (rsp_valid),
      .rsp_covered   (rsp_covered),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Hard stop for a hung run
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic cfg_type make_shape(mode_type mode, int rx, int ry, int ex, int ey,
                                          int cs, int sn, int rch);
      cfg_type s;
      s.shape_mode = mode;
      s.ref_x      = rx;
      s.ref_y      = ry;
      s.extent_x   = ex;
      s.extent_y   = ey;
      s.rot_cos    = cs;
      s.rot_sin    = sn;
      s.reach      = rch;
      return s;
   endfunction

   // Coordinate mostly inside the frame, sometimes anywhere in 16 bits
   function automatic int random_coord();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(0, PIX_MAX);
      end
      return $signed(16'($urandom));
   endfunction

   // Size mostly small so hits are common, with negatives and full range
   function automatic int random_size();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return $urandom_range(0, 200);
      end else if (pick < 80) begin
         return $urandom_range(0, 4000);
      end else if (pick < 90) begin
         return -$urandom_range(1, 200);
      end
      return $signed(16'($urandom));
   endfunction

   function automatic cfg_type random_shape();
      cfg_type s;
      real     angle;
      real     half_diag;
      int      ex, ey;
      s.shape_mode = mode_type'($urandom_range(0, 3));
      s.ref_x      = random_coord();
      s.ref_y      = random_coord();
      if (s.shape_mode == MODE_AXIS_RECT) begin
         ex = random_coord();
         ey = random_coord();
      end else begin
         ex = random_size();
         ey = random_size();
      end
      s.extent_x = ex;
      s.extent_y = ey;
      // rotation from a real angle, now and then raw register values
      angle     = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
      s.rot_cos = $rtoi($floor(16384.0 * $cos(angle) + 0.5));
      s.rot_sin = $rtoi($floor(16384.0 * $sin(angle) + 0.5));
      if ($urandom_range(0, 99) < 15) begin
         s.rot_cos = $urandom;
         s.rot_sin = $urandom;
      end
      half_diag = $sqrt(1.0 * ex * ex + 1.0 * ey * ey) / 2.0;
      if (half_diag > 32767.0) begin
         half_diag = 32767.0;
      end
      s.reach = $rtoi($ceil(half_diag));
      if ($urandom_range(0, 99) < 20) begin
         s.reach = $urandom;
      end
      return s;
   endfunction

   // Aim near the shape most of the time so both outcomes show up
   task automatic aim_pixel(output logic [PIX_W-1:0] x, output logic [PIX_W-1:0] y);
      int cx, cy, spread, vx, vy;
      cx = shape.ref_x;
      cy = shape.ref_y;
      case (shape.shape_mode)
         MODE_AXIS_RECT: begin
            spread = (shape.extent_x > shape.ref_x) ? shape.extent_x - shape.ref_x
                                                    : shape.ref_x - shape.extent_x;
            cx     = (shape.ref_x + shape.extent_x) / 2;
            cy     = (shape.ref_y + shape.extent_y) / 2;
            spread = spread / 2 + 8;
         end
         MODE_ROT_RECT: spread = shape.reach + 8;
         default:       spread = (shape.extent_x < 0) ? 8 - shape.extent_x
                                                      : shape.extent_x + 8;
      endcase
      if (spread > FRAME_DIM) begin
         spread = FRAME_DIM;
      end
      if ($urandom_range(0, 99) < 80) begin
         vx = cx + $urandom_range(0, 2 * spread) - spread;
         vy = cy + $urandom_range(0, 2 * spread) - spread;
         vx = (vx < 0) ? 0 : (vx > PIX_MAX) ? PIX_MAX : vx;
         vy = (vy < 0) ? 0 : (vy > PIX_MAX) ? PIX_MAX : vy;
      end else begin
         vx = $urandom_range(0, PIX_MAX);
         vy = $urandom_range(0, PIX_MAX);
      end
      x = vx;
      y = vy;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Drain the pipeline, then program every register of the shape
   task automatic load_shape(cfg_type s);
      logic [CSR_DATA_W-1:0] data;
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      data      = $urandom;
      data[1:0] = s.shape_mode;
      write_reg(CSR_SHAPE_MODE, data);
      write_reg(CSR_REF_X, s.ref_x);
      write_reg(CSR_REF_Y, s.ref_y);
      // hit an unmapped index now and then; it must change nothing
      if ($urandom_range(0, 2) == 0) begin
         write_reg(CSR_IDX_W'($urandom_range(CSR_REACH + 1, (1 << CSR_IDX_W) - 1)),
                   CSR_DATA_W'($urandom));
      end
      write_reg(CSR_EXTENT_X, s.extent_x);
      write_reg(CSR_EXTENT_Y, s.extent_y);
      write_reg(CSR_ROT_COS, s.rot_cos);
      write_reg(CSR_ROT_SIN, s.rot_sin);
      data                = $urandom;
      data[REACH_W-1:0]   = s.reach;
      write_reg(CSR_REACH, data);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_index = $urandom;
      csr_wdata = $urandom;
      shape     = s;
   endtask

   task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
      @(negedge clock);
      start       = 1'b1;
      req_pixel_x = x;
      req_pixel_y = y;
      do @(posedge clock); while (busy);
      reqs_sent++;
   endtask

   // Close a burst with a random gap; gap_pct of zero keeps start high
   task automatic pace(int gap_pct);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 99) < gap_pct) begin
            @(negedge clock);
            start       = 1'b0;
            req_pixel_x = $urandom;
            req_pixel_y = $urandom;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic stop_requests();
      @(negedge clock);
      start = 1'b0;
   endtask

   initial begin
      logic [PIX_W-1:0] x, y;
      int               phase_len, gap_pct, phase;
      reset       = 1'b1;
      start       = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      shape       = make_shape(MODE_CIRCLE, 0, 0, 0, 0, COS_ONE, 0, 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset shape: zero radius circle covers nothing
      send_pixel(0, 0);
      send_pixel(PIX_MAX, PIX_MAX);
      stop_requests();

      // circle: left edge inside, right edge outside, last row inside, corners by distance
      load_shape(make_shape(MODE_CIRCLE, 100, 100, 10, 0, COS_ONE, 0, 0));
      send_pixel(90, 100);
      send_pixel(110, 100);
      send_pixel(100, 109);
      send_pixel(107, 107);
      send_pixel(92, 92);
      stop_requests();

      // negative radius gives an empty shape
      load_shape(make_shape(MODE_CIRCLE, 100, 100, -5, 0, COS_ONE, 0, 0));
      send_pixel(100, 100);
      stop_requests();

      // square with extreme centre and half side
      load_shape(make_shape(MODE_SQUARE, 32767, -32768, 32767, 0, COS_ONE, 0, 0));
      send_pixel(0, 0);
      stop_requests();
      load_shape(make_shape(MODE_SQUARE, PIX_MAX, 0, 32767, 0, COS_ONE, 0, 0));
      send_pixel(0, PIX_MAX);
      send_pixel(PIX_MAX, 0);
      stop_requests();

      // rectangle given with swapped corners, edges on both sides
      load_shape(make_shape(MODE_AXIS_RECT, 300, 50, 100, 200, COS_ONE, 0, 0));
      send_pixel(100, 50);
      send_pixel(299, 199);
      send_pixel(300, 100);
      send_pixel(150, 200);
      stop_requests();
      load_shape(make_shape(MODE_AXIS_RECT, -32768, 32767, 32767, -32768, COS_ONE, 0, 0));
      send_pixel(0, 0);
      send_pixel(PIX_MAX, PIX_MAX);
      stop_requests();

      // rotated: half-LSB products round away from zero
      load_shape(make_shape(MODE_ROT_RECT, 100, 100, 3, 3, 8192, 0, 100));
      send_pixel(101, 100);
      send_pixel(99, 100);
      send_pixel(100, 101);
      stop_requests();

      // rotated by a quarter turn
      load_shape(make_shape(MODE_ROT_RECT, 500, 500, 20, 6, 0, 16384, 11));
      send_pixel(505, 500);
      send_pixel(500, 502);
      stop_requests();

      // out-of-range trig values and maximum reach
      load_shape(make_shape(MODE_ROT_RECT, 0, 0, 32767, 32767, -32768, -32768, 32767));
      send_pixel(1, 1);
      send_pixel(PIX_MAX, PIX_MAX);
      stop_requests();

      // random shapes, each followed by a burst of pixels around it
      phase = 0;
      while (reqs_sent < TARGET_REQS + 25) begin
         load_shape(random_shape());
         phase_len = $urandom_range(30, 70);
         gap_pct   = (phase % 4 == 0) ? 0 : $urandom_range(10, 60);
         for (int i = 0; i < phase_len; i++) begin
            aim_pixel(x, y);
            send_pixel(x, y);
            pace(gap_pct);
         end
         stop_requests();
         phase++;
      end

      // wait out the pipeline, then give the verdict
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### shape_fill_coverage_test.f
design/sfc_pkg.sv
design/sfc_csr.sv
design/sfc_prod.sv
design/sfc_eval.sv
design/shape_fill_coverage_test.sv
test/shape_fill_coverage_test_checker.sv
test/shape_fill_coverage_test_tb.sv
